// ===== design/cdad_pkg.sv =====
package cdad_pkg;

  localparam int ADD_BITS_DEF  = 16;
  localparam int YEAR_BITS_DEF = 16;

  localparam int DAY_IN_BITS = 5;
  localparam int MONTH_BITS  = 4;
  localparam int LEN_BITS    = 5;

  localparam logic [MONTH_BITS-1:0] MONTH_JAN       = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTHS_PER_YEAR = 4'd12;

  localparam logic [LEN_BITS-1:0] LEN_LONG  = 5'd31;
  localparam logic [LEN_BITS-1:0] LEN_SHORT = 5'd30;
  localparam logic [LEN_BITS-1:0] LEN_LEAP  = 5'd29;
  localparam logic [LEN_BITS-1:0] LEN_FEB   = 5'd28;
  localparam logic [LEN_BITS-1:0] LEN_NONE  = 5'd0;

  // Program steps of the sequencer.
  localparam int STEP_BITS = 2;
  localparam logic [STEP_BITS-1:0] STEP_LOAD = 2'd0;
  localparam logic [STEP_BITS-1:0] STEP_WALK = 2'd1;
  localparam logic [STEP_BITS-1:0] STEP_EMIT = 2'd2;

  // Branch conditions a control word can test.
  localparam int COND_BITS = 2;
  localparam logic [COND_BITS-1:0] COND_IN_VALID  = 2'd0;
  localparam logic [COND_BITS-1:0] COND_DAY_FITS  = 2'd1;
  localparam logic [COND_BITS-1:0] COND_OUT_READY = 2'd2;

  typedef struct packed {
    logic [COND_BITS-1:0] cond;
    logic [STEP_BITS-1:0] next_t;   // taken when the condition holds
    logic [STEP_BITS-1:0] next_f;   // taken otherwise
    logic                 in_rdy;
    logic                 out_vld;
    logic                 do_load;  // acts when the condition holds
    logic                 do_walk;  // acts when the condition fails
  } uword_t;

  // Control store: a read-only table of one control word per step.
  function automatic uword_t microcode(input logic [STEP_BITS-1:0] step);
    uword_t w;
    w = '{cond: COND_IN_VALID, next_t: STEP_LOAD, next_f: STEP_LOAD,
          in_rdy: 1'b0, out_vld: 1'b0, do_load: 1'b0, do_walk: 1'b0};
    case (step)
      STEP_LOAD: begin
        w.cond    = COND_IN_VALID;
        w.next_t  = STEP_WALK;
        w.next_f  = STEP_LOAD;
        w.in_rdy  = 1'b1;
        w.do_load = 1'b1;
      end
      STEP_WALK: begin
        w.cond    = COND_DAY_FITS;
        w.next_t  = STEP_EMIT;
        w.next_f  = STEP_WALK;
        w.do_walk = 1'b1;
      end
      STEP_EMIT: begin
        w.cond    = COND_OUT_READY;
        w.next_t  = STEP_LOAD;
        w.next_f  = STEP_EMIT;
        w.out_vld = 1'b1;
      end
      default: begin
        w.next_t = STEP_LOAD;
        w.next_f = STEP_LOAD;
      end
    endcase
    return w;
  endfunction

  // Invalid month codes have length zero so the walk steps past them.
  function automatic logic [LEN_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] month,
                                                    input logic leap);
    logic [LEN_BITS-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LEN_LONG;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = LEN_SHORT;
      4'd2:                                       len = leap ? LEN_LEAP : LEN_FEB;
      default:                                    len = LEN_NONE;
    endcase
    return len;
  endfunction

endpackage

// ===== design/cdad_if.sv =====
interface cdad_in_if #(
  parameter int ADD_BITS  = cdad_pkg::ADD_BITS_DEF,
  parameter int YEAR_BITS = cdad_pkg::YEAR_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic [cdad_pkg::DAY_IN_BITS-1:0]   start_day;
  logic [cdad_pkg::MONTH_BITS-1:0]    start_month;
  logic [YEAR_BITS-1:0]               start_year;
  logic [ADD_BITS-1:0]                days_to_add;

  modport source (output valid, start_day, start_month, start_year, days_to_add,
                  input ready);
  modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                  output ready);
endinterface

interface cdad_out_if #(
  parameter int YEAR_BITS = cdad_pkg::YEAR_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic [cdad_pkg::DAY_IN_BITS-1:0]   new_day;
  logic [cdad_pkg::MONTH_BITS-1:0]    new_month;
  logic [YEAR_BITS-1:0]               new_year;
  logic                               year_overflow;

  modport source (output valid, new_day, new_month, new_year, year_overflow,
                  input ready);
  modport sink   (input valid, new_day, new_month, new_year, year_overflow,
                  output ready);
endinterface

// ===== design/calendar_date_add_days_unit.sv =====
// The sequencer steps through load, walk and emit. The month walk advances one month per
// cycle through a single subtractor, and covers at most about 2155 months for 16-bit
// counts. No new word is taken until the result is delivered. Synchronous active-high
// reset returns the sequencer to its load step.
module calendar_date_add_days_unit #(
  parameter int ADD_BITS  = cdad_pkg::ADD_BITS_DEF,
  parameter int YEAR_BITS = cdad_pkg::YEAR_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  cdad_in_if.sink         req,
  cdad_out_if.source      rsp
);

  // Day sum holds start_day + days_to_add without loss.
  localparam int DAY_BITS = ADD_BITS + 1;

  logic [cdad_pkg::STEP_BITS-1:0]  step;
  logic [cdad_pkg::STEP_BITS-1:0]  step_next;
  logic [DAY_BITS-1:0]             day;
  logic [cdad_pkg::MONTH_BITS-1:0] month;
  logic [YEAR_BITS-1:0]            year;
  logic                            overflow;

  cdad_pkg::uword_t                uw;
  logic [cdad_pkg::LEN_BITS-1:0]   len;
  logic [DAY_BITS-1:0]             len_ext;
  logic                            fits;
  logic                            cond_true;

  always_comb begin
    uw        = cdad_pkg::microcode(step);
    len       = cdad_pkg::month_len(month, (year[1:0] == 2'b00));
    len_ext   = {{(DAY_BITS-cdad_pkg::LEN_BITS){1'b0}}, len};
    fits      = (day <= len_ext);
    case (uw.cond)
      cdad_pkg::COND_IN_VALID:  cond_true = req.valid;
      cdad_pkg::COND_DAY_FITS:  cond_true = fits;
      cdad_pkg::COND_OUT_READY: cond_true = rsp.ready;
      default:                  cond_true = 1'b1;
    endcase
    step_next = cond_true ? uw.next_t : uw.next_f;
  end

  assign req.ready         = uw.in_rdy;
  assign rsp.valid         = uw.out_vld;
  assign rsp.new_day       = day[cdad_pkg::DAY_IN_BITS-1:0];
  assign rsp.new_month     = month;
  assign rsp.new_year      = year;
  assign rsp.year_overflow = overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= cdad_pkg::STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.do_load && cond_true) begin
      day      <= {{(DAY_BITS-cdad_pkg::DAY_IN_BITS){1'b0}}, req.start_day}
                  + {1'b0, req.days_to_add};
      month    <= req.start_month;
      year     <= req.start_year;
      overflow <= 1'b0;
    end else if (uw.do_walk && !cond_true) begin
      day <= day - len_ext;
      // December and the invalid codes above it roll into January of the next year.
      if (month >= cdad_pkg::MONTHS_PER_YEAR) begin
        month <= cdad_pkg::MONTH_JAN;
        year  <= year + 1'b1;
        if (&year) begin
          overflow <= 1'b1;
        end
      end else begin
        month <= month + 1'b1;
      end
    end
  end

endmodule

// ===== design/cdad_checker.sv =====
module cdad_checker #(
  parameter int YEAR_BITS = cdad_pkg::YEAR_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [cdad_pkg::DAY_IN_BITS-1:0] rsp_day,
  input logic [cdad_pkg::MONTH_BITS-1:0]  rsp_month,
  input logic [YEAR_BITS-1:0]            rsp_year,
  input logic                            rsp_overflow
);

  // A pending result word stays offered until taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped before it was taken");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_day) && $stable(rsp_month)
                               && $stable(rsp_year) && $stable(rsp_overflow))
    else $error("result word changed while stalled");

  // One date at a time: no new word is taken while a result is offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("input taken while a result is pending");

  // No result is offered in the cycle after acceptance; the walk step comes first.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid)
    else $error("result offered in the cycle after acceptance");

endmodule

bind calendar_date_add_days_unit cdad_checker #(.YEAR_BITS(YEAR_BITS)) u_cdad_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_day      (rsp.new_day),
  .rsp_month    (rsp.new_month),
  .rsp_year     (rsp.new_year),
  .rsp_overflow (rsp.year_overflow)
);
